### hdl/plw_pkg.sv
// ----------------------------------------------------------------------------
// plw_pkg
// Shared constants for the pipeline liveness watchdog: field widths,
// register indexes, register reset values and cause codes.
// ----------------------------------------------------------------------------
package plw_pkg;

	localparam int TICK_W    = 32;
	localparam int STACK_W   = 16;
	localparam int CAUSE_W   = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FREE_HEAP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENDER_DEAD_GRACE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_DROP_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DROP_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STACK_WORDS   = 3'd5;

	// register reset values
	localparam logic [TICK_W-1:0]  RST_MIN_FREE_HEAP     = 32'd16384;
	localparam logic [TICK_W-1:0]  RST_STALL_TIMEOUT     = 32'd5000;
	localparam logic [TICK_W-1:0]  RST_SENDER_DEAD_GRACE = 32'd3000;
	localparam logic [TICK_W-1:0]  RST_IDLE_DROP_LIMIT   = 32'd200;
	localparam logic [TICK_W-1:0]  RST_ACTIVE_DROP_LIMIT = 32'd500;
	localparam logic [STACK_W-1:0] RST_MIN_STACK_WORDS   = 16'd256;

	// reboot cause codes
	localparam logic [CAUSE_W-1:0] CAUSE_NONE           = 4'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_HEAP           = 4'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_SENDER_DEAD    = 4'd2;
	localparam logic [CAUSE_W-1:0] CAUSE_FULL_STALL     = 4'd3;
	localparam logic [CAUSE_W-1:0] CAUSE_SENDER_STALL   = 4'd4;
	localparam logic [CAUSE_W-1:0] CAUSE_IDLE_TRANSPORT = 4'd5;
	localparam logic [CAUSE_W-1:0] CAUSE_ACTIVE_DROPS   = 4'd6;
	localparam logic [CAUSE_W-1:0] CAUSE_PRODUCER_STALL = 4'd7;
	localparam logic [CAUSE_W-1:0] CAUSE_STACK          = 4'd8;

endpackage

### hdl/pipeline_liveness_watchdog_unit.sv
// ----------------------------------------------------------------------------
// pipeline_liveness_watchdog_unit
// Path: a transferred check is held in the check register, then moves to the
// result register, which drives the result outputs.
// Throughput: one check per cycle while the result side does not stall; the check
// and the result register each hold one item; watchdog state moves with it.
// Reset: asynchronous, active low; registers take their default limits and
// all watchdog state clears. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Evaluates one periodic liveness check per item against the stored frame
// baselines, progress ticks and sender-dead timer, and reports the first
// reboot cause together with the warning, grace and clear-drops flags.
// ----------------------------------------------------------------------------
module pipeline_liveness_watchdog_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [plw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plw_pkg::CFG_W-1:0]       cfg_data,
	// check channel
	input  logic                            chk_valid,
	output logic                            chk_stall,
	input  logic [plw_pkg::TICK_W-1:0]      now_tick,
	input  logic [plw_pkg::TICK_W-1:0]      heap_bytes,
	input  logic                            streaming_on,
	input  logic [plw_pkg::TICK_W-1:0]      stream_start_tick,
	input  logic [plw_pkg::TICK_W-1:0]      producer_frames,
	input  logic [plw_pkg::TICK_W-1:0]      sender_frames,
	input  logic [plw_pkg::TICK_W-1:0]      sender_drops,
	input  logic                            handles_lock_ok,
	input  logic                            sender_alive,
	input  logic [plw_pkg::STACK_W-1:0]     lowest_stack_words,
	input  logic                            stack_reading_valid,
	// result channel
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            reboot,
	output logic [plw_pkg::CAUSE_W-1:0]     cause,
	output logic                            sender_idle_warning,
	output logic                            in_sender_grace,
	output logic                            clear_drop_count
);
	import plw_pkg::*;

	// configuration registers
	logic [TICK_W-1:0]  min_free_heap_q;
	logic [TICK_W-1:0]  stall_timeout_q;
	logic [TICK_W-1:0]  dead_grace_q;
	logic [TICK_W-1:0]  idle_drop_limit_q;
	logic [TICK_W-1:0]  active_drop_limit_q;
	logic [STACK_W-1:0] min_stack_words_q;

	// check register
	logic               valid_s1;
	logic [TICK_W-1:0]  now_s1;
	logic [TICK_W-1:0]  heap_s1;
	logic               streaming_s1;
	logic [TICK_W-1:0]  start_s1;
	logic [TICK_W-1:0]  prod_s1;
	logic [TICK_W-1:0]  send_s1;
	logic [TICK_W-1:0]  drops_s1;
	logic               lock_s1;
	logic               alive_s1;
	logic [STACK_W-1:0] stack_s1;
	logic               stack_ok_s1;

	// watchdog state
	logic [TICK_W-1:0]  prev_prod_q;
	logic [TICK_W-1:0]  prev_send_q;
	logic [TICK_W-1:0]  prod_prog_q;
	logic [TICK_W-1:0]  send_prog_q;
	logic [TICK_W-1:0]  dead_since_q;
	logic               dead_valid_q;

	// next state and result of the check in the check register
	logic [TICK_W-1:0]  prev_prod_d;
	logic [TICK_W-1:0]  prev_send_d;
	logic [TICK_W-1:0]  prod_prog_d;
	logic [TICK_W-1:0]  send_prog_d;
	logic [TICK_W-1:0]  dead_since_d;
	logic               dead_valid_d;
	logic [CAUSE_W-1:0] cause_c;
	logic               warn_c;
	logic               grace_c;
	logic               clr_c;
	logic               skip_stack_c;

	// shared compare terms
	logic               advance;
	logic               heap_low;
	logic               past_start;
	logic               prod_moved;
	logic               send_moved;
	logic               send_old;
	logic               prod_old;
	logic               dead_expired;
	logic               only_prod;
	logic               idle_send;
	logic [TICK_W-1:0]  dead_age;

	assign cfg_ready = 1'b1;

	// move the check into the result register when it is free or being taken
	assign advance   = valid_s1 && (!res_valid || !res_stall);
	assign chk_stall = valid_s1 && !advance;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_free_heap_q     <= RST_MIN_FREE_HEAP;
			stall_timeout_q     <= RST_STALL_TIMEOUT;
			dead_grace_q        <= RST_SENDER_DEAD_GRACE;
			idle_drop_limit_q   <= RST_IDLE_DROP_LIMIT;
			active_drop_limit_q <= RST_ACTIVE_DROP_LIMIT;
			min_stack_words_q   <= RST_MIN_STACK_WORDS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_FREE_HEAP:     min_free_heap_q     <= cfg_data;
				REG_STALL_TIMEOUT:     stall_timeout_q     <= cfg_data;
				REG_SENDER_DEAD_GRACE: dead_grace_q        <= cfg_data;
				REG_IDLE_DROP_LIMIT:   idle_drop_limit_q   <= cfg_data;
				REG_ACTIVE_DROP_LIMIT: active_drop_limit_q <= cfg_data;
				REG_MIN_STACK_WORDS:   min_stack_words_q   <= cfg_data[STACK_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the check on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!chk_stall) begin
			valid_s1 <= chk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chk_valid && !chk_stall) begin
			now_s1       <= now_tick;
			heap_s1      <= heap_bytes;
			streaming_s1 <= streaming_on;
			start_s1     <= stream_start_tick;
			prod_s1      <= producer_frames;
			send_s1      <= sender_frames;
			drops_s1     <= sender_drops;
			lock_s1      <= handles_lock_ok;
			alive_s1     <= sender_alive;
			stack_s1     <= lowest_stack_words;
			stack_ok_s1  <= stack_reading_valid;
		end
	end

	// compare terms; tick differences wrap modulo 2^32
	assign dead_age     = dead_valid_q ? (now_s1 - dead_since_q) : '0;
	assign heap_low     = heap_s1 < min_free_heap_q;
	assign past_start   = (now_s1 - start_s1) >= stall_timeout_q;
	assign prod_moved   = prod_s1 != prev_prod_q;
	assign send_moved   = send_s1 != prev_send_q;
	assign send_old     = (now_s1 - send_prog_q) >= stall_timeout_q;
	assign prod_old     = (now_s1 - prod_prog_q) >= stall_timeout_q;
	assign dead_expired = dead_age > dead_grace_q;
	assign only_prod    = prod_moved && !send_moved;
	assign idle_send    = only_prod && (send_s1 == '0) && send_old;

	// evaluate the check in priority order
	always_comb begin
		cause_c      = CAUSE_NONE;
		warn_c       = 1'b0;
		grace_c      = 1'b0;
		clr_c        = 1'b0;
		skip_stack_c = 1'b0;
		prev_prod_d  = prev_prod_q;
		prev_send_d  = prev_send_q;
		prod_prog_d  = prod_prog_q;
		send_prog_d  = send_prog_q;
		dead_since_d = dead_since_q;
		dead_valid_d = dead_valid_q;

		if (heap_low) begin
			cause_c = CAUSE_HEAP;
		end else if (streaming_s1) begin
			if (past_start) begin
				if (!lock_s1) begin
					// no lock: rebase counts, report nothing
					prev_prod_d  = prod_s1;
					prev_send_d  = send_s1;
					skip_stack_c = 1'b1;
				end else if (!alive_s1) begin
					// sender gone: start or run the grace timer
					skip_stack_c = 1'b1;
					if (!dead_valid_q) begin
						dead_valid_d = 1'b1;
						dead_since_d = now_s1;
					end
					if (dead_expired) begin
						cause_c = CAUSE_SENDER_DEAD;
					end else begin
						prev_prod_d = prod_s1;
						prev_send_d = send_s1;
						grace_c     = 1'b1;
					end
				end else begin
					dead_valid_d = 1'b0;
					dead_since_d = '0;
					if (prod_moved) begin
						prod_prog_d = now_s1;
					end
					if (send_moved) begin
						send_prog_d = now_s1;
					end
					if (!prod_moved && !send_moved) begin
						cause_c = CAUSE_FULL_STALL;
					end else if (only_prod && (send_s1 != '0) && send_old) begin
						cause_c = CAUSE_SENDER_STALL;
					end else if (idle_send && (drops_s1 > idle_drop_limit_q)) begin
						cause_c = CAUSE_IDLE_TRANSPORT;
					end else begin
						if (idle_send) begin
							warn_c      = 1'b1;
							send_prog_d = now_s1;
						end
						if (only_prod && (send_s1 != '0)
								&& (drops_s1 > active_drop_limit_q)) begin
							cause_c = CAUSE_ACTIVE_DROPS;
						end else if (!prod_moved && send_moved && prod_old) begin
							cause_c = CAUSE_PRODUCER_STALL;
						end else begin
							prev_prod_d = prod_s1;
							prev_send_d = send_s1;
						end
					end
				end
			end
		end else begin
			// idle stream: rebase everything and ask for a drop clear
			prev_prod_d  = prod_s1;
			prev_send_d  = send_s1;
			prod_prog_d  = now_s1;
			send_prog_d  = now_s1;
			dead_valid_d = 1'b0;
			dead_since_d = '0;
			clr_c        = 1'b1;
		end

		if ((cause_c == CAUSE_NONE) && !skip_stack_c && stack_ok_s1
				&& (stack_s1 < min_stack_words_q)) begin
			cause_c = CAUSE_STACK;
		end

		// a reboot drops the flags and returns the state to reset
		if (cause_c != CAUSE_NONE) begin
			warn_c       = 1'b0;
			grace_c      = 1'b0;
			clr_c        = 1'b0;
			prev_prod_d  = '0;
			prev_send_d  = '0;
			prod_prog_d  = '0;
			send_prog_d  = '0;
			dead_since_d = '0;
			dead_valid_d = 1'b0;
		end
	end

	// advance watchdog state with the check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_prod_q  <= '0;
			prev_send_q  <= '0;
			prod_prog_q  <= '0;
			send_prog_q  <= '0;
			dead_since_q <= '0;
			dead_valid_q <= 1'b0;
		end else if (advance) begin
			prev_prod_q  <= prev_prod_d;
			prev_send_q  <= prev_send_d;
			prod_prog_q  <= prod_prog_d;
			send_prog_q  <= send_prog_d;
			dead_since_q <= dead_since_d;
			dead_valid_q <= dead_valid_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (!res_valid || !res_stall) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			reboot              <= cause_c != CAUSE_NONE;
			cause               <= cause_c;
			sender_idle_warning <= warn_c;
			in_sender_grace     <= grace_c;
			clear_drop_count    <= clr_c;
		end
	end

	// a reboot leaves the watchdog state at reset
	a_reboot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cause_c != CAUSE_NONE)
		|=> !dead_valid_q && (prev_prod_q == '0) && (send_prog_q == '0))
		else $error("watchdog state not cleared after reboot");

	// a shown grace result means the dead timer is running
	a_grace_timer: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && in_sender_grace |-> dead_valid_q)
		else $error("grace reported without a running dead timer");

	// a reboot result carries no side flags
	a_reboot_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && reboot
		|-> !sender_idle_warning && !in_sender_grace && !clear_drop_count)
		else $error("reboot result carries side flags");

	// the check side stalls only while a check is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		chk_stall |-> valid_s1 && res_valid)
		else $error("check stalled with nothing held");

endmodule
